[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// A condition that must hold at the same edge as its trigger.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// A condition that must hold at the edge after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/ssrc_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo sample ring chunker package
// Sizes, types and codes shared by the ring chunker and its sample RAM.
// ----------------------------------------------------------------------------
package ssrc_pkg;

    localparam int RING_DEPTH    = 8192;
    localparam int CHUNK_SAMPLES = 1024;
    localparam int SAMPLE_BITS   = 16;

    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int PAIR_DEPTH = RING_DEPTH / 2;
    localparam int OFF_W      = $clog2(CHUNK_SAMPLES);
    localparam int CNT_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;

    typedef logic        [IDX_W-1:0]       t_idx;
    typedef logic        [OFF_W-1:0]       t_off;
    typedef logic        [CNT_W-1:0]       t_cnt;
    typedef logic        [FUNC_W-1:0]      t_func;
    typedef logic        [STATUS_W-1:0]    t_status;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // Item functions.
    localparam t_func FN_PUSH  = 2'd0;
    localparam t_func FN_READ  = 2'd1;
    localparam t_func FN_FLUSH = 2'd2;
    localparam t_func FN_FAULT = 2'd3;

    // Result status codes.
    localparam t_status ST_STORED   = 3'd0;
    localparam t_status ST_DROPPED  = 3'd1;
    localparam t_status ST_GIVEN    = 3'd2;
    localparam t_status ST_NO_CHUNK = 3'd3;
    localparam t_status ST_FLUSHED  = 3'd4;
    localparam t_status ST_FAULT    = 3'd5;

endpackage

[rtl/ssrc_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its data
// while the read enable is low.
// ----------------------------------------------------------------------------
module ssrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/stereo_sample_ring_chunker_core.sv]
// ----------------------------------------------------------------------------
// Stereo sample ring chunker
// Ring store of PCM samples filled by stereo pairs and drained one chunk at a
// time, with drop and fault counters.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on both channels while the result side takes each result, every function alike.
// Result path: two register stages hold each result word, stage one and then
// the output register, the first alongside the registered read of the sample RAM.
// Reset (synchronous, active low) clears the indexes, chunk state, counters and
// pipeline valids at once; the sample RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module stereo_sample_ring_chunker_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssrc_pkg::t_func   i_func,
    input  ssrc_pkg::t_sample i_left_sample,
    input  ssrc_pkg::t_sample i_right_sample,
    output logic              o_valid,
    input  logic              i_ready,
    output ssrc_pkg::t_status o_status,
    output ssrc_pkg::t_sample o_sample_out,
    output logic              o_last_in_chunk,
    output ssrc_pkg::t_cnt    o_chunk_number,
    output ssrc_pkg::t_idx    o_fill_level,
    output ssrc_pkg::t_cnt    o_dropped_count,
    output ssrc_pkg::t_cnt    o_fault_count
);

    import ssrc_pkg::*;

`include "assert_macros.svh"

    // Pushes always add two samples, flushes copy the write index and chunks
    // are an even number of samples, so the write index is always even. The
    // ring is therefore held as a RAM of left/right pairs: one push is one
    // RAM write, and a read picks one half of a pair.

    // Ring state.
    t_idx r_wr_idx, n_wr_idx;
    t_idx r_rd_idx, n_rd_idx;
    t_off r_chunk_off, n_chunk_off;
    t_cnt r_chunk_seq, n_chunk_seq;
    t_cnt r_dropped, n_dropped;
    t_cnt r_faults, n_faults;

    // Stage one: result fields wait here for the RAM read data.
    logic    r_s1_valid;
    t_status r_s1_status;
    logic    r_s1_last;
    logic    r_s1_half;
    t_cnt    r_s1_number;
    t_idx    r_s1_fill;
    t_cnt    r_s1_dropped;
    t_cnt    r_s1_faults;

    // Output register.
    logic    r_out_valid;
    t_status r_out_status;
    t_sample r_out_sample;
    logic    r_out_last;
    t_cnt    r_out_number;
    t_idx    r_out_fill;
    t_cnt    r_out_dropped;
    t_cnt    r_out_faults;

    logic    w_in_acc;
    logic    w_s1_move;
    t_idx    w_used;
    logic    w_push_ok;
    logic    w_chunk_open;
    logic    w_last;
    t_idx    w_rd_slot;
    t_status w_status;
    logic    w_ram_we;
    logic    w_ram_re;
    logic [2*SAMPLE_BITS-1:0] w_ram_rdata;

    // Handshake: the output register drains first, stage one follows, and a
    // new word enters whenever stage one is empty or moving on.
    assign w_s1_move = !r_out_valid || i_ready;
    assign o_ready   = !r_s1_valid || w_s1_move;
    assign w_in_acc  = i_valid && o_ready;

    // Occupancy wraps with the index width, which matches the ring depth.
    assign w_used    = r_wr_idx - r_rd_idx;
    // A push needs two free slots, one slot always stays empty.
    assign w_push_ok = w_used <= t_idx'(RING_DEPTH - 3);
    // A read succeeds inside an open chunk, or when a whole chunk is buffered.
    assign w_chunk_open = (r_chunk_off != '0) ||
                          (32'(w_used) >= 32'(CHUNK_SAMPLES));
    assign w_last    = r_chunk_off == t_off'(CHUNK_SAMPLES - 1);
    assign w_rd_slot = r_rd_idx + t_idx'(r_chunk_off);

    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_chunk_off = r_chunk_off;
        n_chunk_seq = r_chunk_seq;
        n_dropped   = r_dropped;
        n_faults    = r_faults;
        w_status    = ST_STORED;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        unique case (i_func)
            FN_PUSH: begin
                if (w_push_ok) begin
                    w_ram_we = w_in_acc;
                    n_wr_idx = r_wr_idx + t_idx'(2);
                    w_status = ST_STORED;
                end else begin
                    n_dropped = r_dropped + t_cnt'(1);
                    w_status  = ST_DROPPED;
                end
            end
            FN_READ: begin
                if (!w_chunk_open) begin
                    w_status = ST_NO_CHUNK;
                end else begin
                    w_ram_re = w_in_acc;
                    w_status = ST_GIVEN;
                    if (w_last) begin
                        // The chunk's last sample commits the read index.
                        n_rd_idx    = r_rd_idx + t_idx'(CHUNK_SAMPLES);
                        n_chunk_off = '0;
                        n_chunk_seq = r_chunk_seq + t_cnt'(1);
                    end else begin
                        n_chunk_off = r_chunk_off + t_off'(1);
                    end
                end
            end
            FN_FLUSH: begin
                n_rd_idx    = r_wr_idx;
                n_chunk_off = '0;
                w_status    = ST_FLUSHED;
            end
            FN_FAULT: begin
                n_faults = r_faults + t_cnt'(1);
                w_status = ST_FAULT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_chunk_off <= '0;
            r_chunk_seq <= '0;
            r_dropped   <= '0;
            r_faults    <= '0;
        end else if (w_in_acc) begin
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_chunk_off <= n_chunk_off;
            r_chunk_seq <= n_chunk_seq;
            r_dropped   <= n_dropped;
            r_faults    <= n_faults;
        end
    end

    // Pair RAM. The read data register holds while stage one is stalled,
    // because a read is only issued when a new word enters.
    ssrc_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (PAIR_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_idx[IDX_W-1:1]),
        .i_wdata ({i_right_sample, i_left_sample}),
        .i_re    (w_ram_re),
        .i_raddr (w_rd_slot[IDX_W-1:1]),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_status  <= w_status;
            r_s1_last    <= (w_status == ST_GIVEN) && w_last;
            r_s1_half    <= w_rd_slot[0];
            r_s1_number  <= r_chunk_seq;
            r_s1_fill    <= n_wr_idx - n_rd_idx;
            r_s1_dropped <= n_dropped;
            r_s1_faults  <= n_faults;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move && r_s1_valid) begin
            r_out_status <= r_s1_status;
            if (r_s1_status != ST_GIVEN) begin
                r_out_sample <= '0;
            end else if (r_s1_half) begin
                r_out_sample <= w_ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            end else begin
                r_out_sample <= w_ram_rdata[SAMPLE_BITS-1:0];
            end
            r_out_last    <= r_s1_last;
            r_out_number  <= r_s1_number;
            r_out_fill    <= r_s1_fill;
            r_out_dropped <= r_s1_dropped;
            r_out_faults  <= r_s1_faults;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_sample_out    = r_out_sample;
    assign o_last_in_chunk = r_out_last;
    assign o_chunk_number  = r_out_number;
    assign o_fill_level    = r_out_fill;
    assign o_dropped_count = r_out_dropped;
    assign o_fault_count   = r_out_faults;

    // The write index only ever moves in steps of two.
    `ASSERT_ALWAYS(a_wr_idx_even, i_clk, i_rst_n, r_wr_idx[0] == 1'b0)
    // While a chunk is open, a whole chunk stays buffered behind the read index.
    `ASSERT_IMPLY(a_open_chunk_buffered, i_clk, i_rst_n, r_chunk_off != '0, 32'(w_used) >= 32'(CHUNK_SAMPLES))
    // An accepted word always lands in stage one.
    `ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, w_in_acc, r_s1_valid)
    // Only a given sample carries sample data or a chunk end.
    `ASSERT_IMPLY(a_sample_only_given, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_GIVEN), (r_out_sample == '0) && !r_out_last)

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo sample ring chunker testbench
// Drives push, read, flush and fault words into the ring chunker with random
// gaps on the input side and random stalls on the result side. Every accepted
// word is run through a local copy of the ring, its indexes and its counters,
// and the result word that comes back is compared field by field against it.
// ----------------------------------------------------------------------------
module tb;

    import ssrc_pkg::*;

    // Random part of the run, in input words.
    localparam int RANDOM_WORDS = 150;
    // Cycles without any handshake on either side before the run is declared hung.
    // The longest legal pause is the longest input gap next to the longest result
    // stall plus the pipeline, so this leaves a wide margin.
    localparam int QUIET_LIMIT  = 1000;
    // Extra cycles after the last expected result; the pipeline is two deep.
    localparam int DRAIN_CYCLES = 4;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    // One result word as the block should return it.
    typedef struct {
        t_status status;
        t_sample sample;
        logic    last;
        t_cnt    number;
        t_idx    fill;
        t_cnt    dropped;
        t_cnt    faults;
    } t_ring_result;

    logic    i_clk          = 1'b0;
    logic    i_rst_n        = 1'b0;
    logic    i_valid        = 1'b0;
    logic    o_ready;
    t_func   i_func         = FN_PUSH;
    t_sample i_left_sample  = '0;
    t_sample i_right_sample = '0;
    logic    o_valid;
    logic    i_ready        = 1'b0;
    t_status o_status;
    t_sample o_sample_out;
    logic    o_last_in_chunk;
    t_cnt    o_chunk_number;
    t_idx    o_fill_level;
    t_cnt    o_dropped_count;
    t_cnt    o_fault_count;

    stereo_sample_ring_chunker_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_left_sample   (i_left_sample),
        .i_right_sample  (i_right_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_sample_out    (o_sample_out),
        .o_last_in_chunk (o_last_in_chunk),
        .o_chunk_number  (o_chunk_number),
        .o_fill_level    (o_fill_level),
        .o_dropped_count (o_dropped_count),
        .o_fault_count   (o_fault_count)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Local copy of the block's state, starting from its reset values. Ring
    // slots are only ever read between the committed read index and the write
    // index, so the slots that were never written are left undefined here too.
    // ------------------------------------------------------------------------
    t_sample     ring_copy [RING_DEPTH];
    t_idx        wr_copy     = '0;
    t_idx        rd_copy     = '0;
    int unsigned offset_copy = 0;
    t_cnt        seq_copy    = '0;
    t_cnt        drops_copy  = '0;
    t_cnt        faults_copy = '0;

    // Results owed by the block, oldest first.
    t_ring_result pending_results [$];
    t_ring_result oldest_result;

    int fail_count  = 0;
    int stall_left  = 0;
    int quiet_count = 0;
    // Random gaps and stalls are switched off for the final stretch of the run.
    bit idle_on     = 1'b1;

    // Samples between the committed read index and the write index. The
    // subtraction wraps at the ring size because both indexes are IDX_W wide.
    function automatic t_idx buffered_samples();
        return t_idx'(wr_copy - rd_copy);
    endfunction

    // Applies one input word to the local state and returns the result word
    // that the block has to produce for it.
    function automatic t_ring_result predict_ring_step(t_func fn, t_sample left,
                                                       t_sample right);
        t_ring_result res;
        t_idx         used;
        used        = buffered_samples();
        res.status  = ST_STORED;
        res.sample  = '0;
        res.last    = 1'b0;
        res.number  = seq_copy;
        case (fn)
            FN_PUSH: begin
                // One slot always stays empty, so a pair needs two of the
                // RING_DEPTH-1 usable slots.
                if (t_idx'(RING_DEPTH - 1) - used >= 2) begin
                    ring_copy[wr_copy] = left;
                    wr_copy            = t_idx'(wr_copy + 1);
                    ring_copy[wr_copy] = right;
                    wr_copy            = t_idx'(wr_copy + 1);
                    res.status         = ST_STORED;
                end else begin
                    drops_copy = drops_copy + 1;
                    res.status = ST_DROPPED;
                end
            end
            FN_READ: begin
                // A chunk opens only when a whole one is buffered; once open,
                // its samples stay put because pushes respect the committed
                // read index.
                if (offset_copy == 0 && used < CHUNK_SAMPLES) begin
                    res.status = ST_NO_CHUNK;
                end else begin
                    res.sample  = ring_copy[t_idx'(rd_copy + offset_copy)];
                    res.status  = ST_GIVEN;
                    offset_copy = offset_copy + 1;
                    if (offset_copy >= CHUNK_SAMPLES) begin
                        res.last    = 1'b1;
                        rd_copy     = t_idx'(rd_copy + CHUNK_SAMPLES);
                        offset_copy = 0;
                        seq_copy    = seq_copy + 1;
                    end
                end
            end
            FN_FLUSH: begin
                // The backlog goes, the sequence number stays.
                rd_copy     = wr_copy;
                offset_copy = 0;
                res.status  = ST_FLUSHED;
            end
            default: begin
                faults_copy = faults_copy + 1;
                res.status  = ST_FAULT;
            end
        endcase
        res.fill    = buffered_samples();
        res.dropped = drops_copy;
        res.faults  = faults_copy;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. The task is entered just after a rising edge. It may first
    // hold valid low for a random burst, then presents the word and waits for
    // the edge at which o_ready is seen high. Valid is left high on return so
    // that a back-to-back word never lowers and raises it in one time step.
    // ------------------------------------------------------------------------
    task automatic send_word(t_func fn, t_sample left, t_sample right);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= fn;
        i_left_sample  <= left;
        i_right_sample <= right;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_ring_step(fn, left, right));
    endtask

    task automatic push_random_pair();
        send_word(FN_PUSH, t_sample'($urandom), t_sample'($urandom));
    endtask

    // Sample fields carry random content on non-push words too; the block
    // must ignore them there.
    task automatic read_samples(int count);
        repeat (count) send_word(FN_READ, t_sample'($urandom), t_sample'($urandom));
    endtask

    task automatic fill_to(int target);
        while (buffered_samples() < target) push_random_pair();
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each accepted result word against the oldest
    // expectation, then decide whether to stall the next cycle.
    // ------------------------------------------------------------------------
    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word arrived with no expected result waiting");
                    fail_count++;
                end else begin
                    oldest_result = pending_results.pop_front();
                    compare_field("status", oldest_result.status, o_status);
                    compare_field("sample_out", oldest_result.sample, o_sample_out);
                    compare_field("last_in_chunk", oldest_result.last, o_last_in_chunk);
                    compare_field("chunk_number", oldest_result.number, o_chunk_number);
                    compare_field("fill_level", oldest_result.fill, o_fill_level);
                    compare_field("dropped_count", oldest_result.dropped,
                                  o_dropped_count);
                    compare_field("fault_count", oldest_result.faults, o_fault_count);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 11);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Hang detection: any handshake on either channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty ring after reset: reads find no chunk, flush and fault work on an
    // empty ring, and the sample extremes go into the ring.
    task automatic test_empty_ring();
        read_samples(1);
        send_word(FN_FLUSH, SAMPLE_MAX, SAMPLE_MIN);
        send_word(FN_FAULT, SAMPLE_MIN, SAMPLE_MAX);
        send_word(FN_FAULT, '0, '1);
        send_word(FN_PUSH, SAMPLE_MAX, SAMPLE_MIN);
        send_word(FN_PUSH, SAMPLE_MIN, SAMPLE_MAX);
        send_word(FN_PUSH, '0, '1);
        send_word(FN_PUSH, '1, '0);
        read_samples(1);
        send_word(FN_FAULT, t_sample'($urandom), t_sample'($urandom));
        send_word(FN_FLUSH, t_sample'($urandom), t_sample'($urandom));
        read_samples(1);
    endtask

    // A chunk opens exactly when a whole chunk is buffered: one pair short it
    // stays shut, with the final pair its first samples come out in order.
    task automatic test_chunk_boundary();
        fill_to(CHUNK_SAMPLES - 2);
        read_samples(1);
        push_random_pair();
        read_samples(8);
    endtask

    // A flush after pushes and a fault drops the backlog and any open chunk, keeps
    // the sequence number, and a read right after finds no chunk.
    task automatic test_flush_mid_chunk();
        repeat (4) push_random_pair();
        send_word(FN_FAULT, t_sample'($urandom), t_sample'($urandom));
        send_word(FN_FLUSH, t_sample'($urandom), t_sample'($urandom));
        read_samples(1);
    endtask

    // Random traffic in phases that lean toward pushing or toward reading, so
    // that the open chunk keeps being read while pairs arrive, with rare
    // flushes and some faults. The last quarter runs without gaps or stalls.
    task automatic test_random_traffic();
        int  n;
        int  phase_left;
        int  pick;
        bit  push_heavy;
        phase_left = 0;
        push_heavy = 1'b0;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS * 3 / 4) idle_on <= 1'b0;
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                push_heavy = $urandom_range(0, 1);
            end
            phase_left--;
            pick = $urandom_range(0, 399);
            if (pick == 0) begin
                send_word(FN_FLUSH, t_sample'($urandom), t_sample'($urandom));
            end else if (pick < 20) begin
                send_word(FN_FAULT, t_sample'($urandom), t_sample'($urandom));
            end else if (push_heavy ? (pick < 330) : (pick >= 330)) begin
                push_random_pair();
            end else begin
                read_samples(1);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_ring();
        test_chunk_boundary();
        test_random_traffic();
        test_flush_mid_chunk();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        // Decide away from the edge so that a late result word is counted.
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
